// ===== design/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int TDATA_W    = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_START = 5'b00100,
    S_RED   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    OP_BASE = 2'd0,
    OP_ACC  = 2'd1,
    OP_SQR  = 2'd2
  } op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } red_stat_t;

endpackage

// ===== design/modular_exponentiation.sv =====
`timescale 1ns / 1ps
// Each modular product is reduced by the shared remainder unit, which retires two product
// bits per cycle; one item is in work at a time, and a new base word is not taken
// until the result has been transferred. Reset: synchronous, active high;
// exponent returns to 1, modulus to 2, the sequencer to idle.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply over the exponent bits using one registered multiplier
// and one iterative remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mexp_pkg::TDATA_W-1:0]       s_axis_tdata,   // [31:0] base_value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mexp_pkg::TDATA_W-1:0]       m_axis_tdata,   // [31:0] power_result
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mexp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mexp_pkg::*;

  localparam int W = DATA_WIDTH;

  state_t           state, state_next;
  op_t              op, op_next;
  logic [CFG_DATA_W-1:0] exponent_reg;
  logic [CFG_DATA_W-1:0] modulus_reg;
  logic [W-1:0]     mod_w;
  logic [W-1:0]     acc, acc_next;
  logic [W-1:0]     sq, sq_next;
  logic [W-1:0]     exp_sh, exp_next;
  logic [W-1:0]     exp_dec;
  logic [W-1:0]     mul_a, mul_b;
  logic [2*W-1:0]   prod;
  logic             red_start;
  red_stat_t        red_stat;
  logic [W-1:0]     red_rem;
  logic             in_xfer, out_xfer;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = TDATA_W'(acc);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_axis_tvalid && m_axis_tready;
  assign mod_w         = modulus_reg[W-1:0];
  assign red_start     = (state == S_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent_reg <= CFG_DATA_W'(1);
      modulus_reg  <= CFG_DATA_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXPONENT: exponent_reg <= cfg_data;
        REG_MODULUS:  modulus_reg  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mul_a = (op == OP_ACC) ? acc : sq;
  assign mul_b = (op == OP_BASE) ? W'(1) : sq;

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= mul_a * mul_b;
    end
  end

  mexp_reduce #(
    .DATA_WIDTH (W)
  ) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .start     (red_start),
    .product   (prod),
    .modulus   (mod_w),
    .stat      (red_stat),
    .remainder (red_rem)
  );

  assign exp_dec = (op == OP_SQR) ? (exp_sh >> 1) : exp_sh;

  always_comb begin
    state_next = state;
    op_next    = op;
    acc_next   = acc;
    sq_next    = sq;
    exp_next   = exp_sh;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          sq_next  = s_axis_tdata[W-1:0];
          exp_next = exponent_reg[W-1:0];
          if (mod_w == '0) begin
            acc_next   = '0;
            state_next = S_OUT;
          end else begin
            acc_next   = (mod_w == W'(1)) ? '0 : W'(1);
            op_next    = OP_BASE;
            state_next = S_MUL;
          end
        end
      end
      S_MUL:   state_next = S_START;
      S_START: state_next = S_RED;
      S_RED: begin
        if (red_stat.done) begin
          case (op)
            OP_BASE, OP_SQR: begin
              sq_next  = red_rem;
              exp_next = exp_dec;
              if (exp_dec == '0) begin
                state_next = S_OUT;
              end else begin
                op_next    = exp_dec[0] ? OP_ACC : OP_SQR;
                state_next = S_MUL;
              end
            end
            OP_ACC: begin
              acc_next = red_rem;
              if (exp_sh[W-1:1] == '0) begin
                state_next = S_OUT;
              end else begin
                op_next    = OP_SQR;
                state_next = S_MUL;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_BASE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_ff @(posedge clk) begin
    acc    <= acc_next;
    sq     <= sq_next;
    exp_sh <= exp_next;
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready while a result is pending");

  a_done_in_red: assert property (@(posedge clk) disable iff (rst)
    red_stat.done |-> (state == S_RED))
    else $error("remainder done outside the wait state");

  a_start_idle_unit: assert property (@(posedge clk) disable iff (rst)
    red_start |-> !red_stat.busy)
    else $error("remainder unit started while busy");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("ready held after an input transfer");
`endif

endmodule

// ===== design/mexp_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_reduce
// Iterative remainder unit: reduces a double-width product by the modulus,
// two dividend bits per cycle with restoring compare and subtract.
// ----------------------------------------------------------------------------
module mexp_reduce #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [2*DATA_WIDTH-1:0]     product,
  input  logic [DATA_WIDTH-1:0]       modulus,
  output mexp_pkg::red_stat_t         stat,
  output logic [DATA_WIDTH-1:0]       remainder
);
  import mexp_pkg::*;

  localparam int W     = DATA_WIDTH;
  localparam int CNT_W = $clog2(W);

  logic [2*W-1:0]   dividend;
  logic [W-1:0]     rem;
  logic [W-1:0]     rem_next;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  function automatic logic [W-1:0] rstep(input logic [W-1:0] r, input logic b,
                                         input logic [W-1:0] m);
    logic [W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[W-1:0];
  endfunction

  assign rem_next = rstep(rstep(rem, dividend[2*W-1], modulus), dividend[2*W-2], modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= product;
      rem      <= '0;
    end else if (busy) begin
      dividend <= {dividend[2*W-3:0], 2'b00};
      rem      <= rem_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

// ===== dv/modular_exponentiation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_test
// Self-checking bench for the modular exponentiation block. A table of
// directed cases covers reset values, operand extremes and the degenerate
// keys. Randomized phases follow, each loading a new exponent and modulus and
// streaming base words. Every returned power is checked in order against the
// table or a square-and-multiply predictor. Both stream sides idle in bursts.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;
  import mexp_pkg::*;

  localparam int OPERAND_W    = 32;
  localparam int NUM_VEC      = 24;
  localparam int NUM_PHASES   = 13;
  localparam int HOLD_CYCLES  = 5000;
  localparam int TAIL_CYCLES  = 2400;
  localparam int LIMIT_CYCLES = 10_000_000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [31:0] exponent;
    logic [31:0] modulus;
    logic [31:0] base;
    logic        known;
    logic [31:0] power;
  } power_case_t;

  localparam power_case_t DIRECTED [NUM_VEC] = '{
    '{32'd1,          32'd2,          32'd0,          1'b1, 32'd0},
    '{32'd1,          32'd2,          32'd1,          1'b1, 32'd1},
    '{32'd1,          32'd2,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'd0,          32'd7,          32'd5,          1'b1, 32'd1},
    '{32'd0,          32'd2,          32'd0,          1'b1, 32'd1},
    '{32'd5,          32'd1,          32'd3,          1'b1, 32'd0},
    '{32'd5,          32'd0,          32'd3,          1'b1, 32'd0},
    '{32'd0,          32'd0,          32'd0,          1'b1, 32'd0},
    '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 32'd0},
    '{32'd1,          32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
    '{32'd1,          32'd1000,       32'd1234,       1'b1, 32'd234},
    '{32'd2,          32'd1000,       32'd12,         1'b1, 32'd144},
    '{32'h8000_0000,  32'hFFFF_FFFB,  32'd3,          1'b0, 32'd0},
    '{32'd17,         32'd3233,       32'd65,         1'b1, 32'd2790},
    '{32'd2753,       32'd3233,       32'd2790,       1'b1, 32'd65},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFE,  1'b1, 32'hFFFF_FFFE},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,          1'b1, 32'd0},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd1,          1'b1, 32'd1},
    '{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hDEAD_BEEF,  1'b0, 32'd0},
    '{32'hFFFF_FFFF,  32'd2,          32'hFFFF_FFFF,  1'b1, 32'd1},
    '{32'hFFFF_FFFF,  32'd2,          32'hFFFF_FFFE,  1'b1, 32'd0},
    '{32'd65537,      32'hFFFF_FFFB,  32'h1234_5678,  1'b0, 32'd0},
    '{32'hFFFF_FFFA,  32'hFFFF_FFFB,  32'd2,          1'b1, 32'd1},
    '{32'd3,          32'h8000_0000,  32'h7FFF_FFFF,  1'b0, 32'd0}
  };

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = REG_EXPONENT;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  logic [31:0] key_exponent = 32'd1;
  logic [31:0] key_modulus  = 32'd2;
  logic [31:0] pending_powers [$];
  logic [31:0] oldest_power;
  logic        idle_on      = 1'b1;
  logic        hold_sink    = 1'b0;
  int          error_count  = 0;
  int          cycle_count  = 0;

  modular_exponentiation u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] mod_power(input logic [31:0] base,
                                            input logic [31:0] exponent,
                                            input logic [31:0] modulus);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] m;
    m = {32'd0, modulus};
    if (m == 64'd0) begin
      return 32'd0;
    end
    acc = 64'd1 % m;
    sq  = {32'd0, base} % m;
    for (int b = 0; b < OPERAND_W; b++) begin
      if (exponent[b]) begin
        acc = (acc * sq) % m;
      end
      sq = (sq * sq) % m;
    end
    return acc[31:0];
  endfunction

  function automatic logic [31:0] rand_exponent(input int lo, input int hi);
    int          k;
    logic [31:0] e;
    k = $urandom_range(lo, hi);
    e = $urandom;
    if (k < 32) begin
      e = e & ((32'd1 << k) - 32'd1);
    end
    e[k-1] = 1'b1;
    return e;
  endfunction

  function automatic logic [31:0] rand_modulus();
    logic [31:0] m;
    m = $urandom;
    return (m < 32'd2) ? 32'd2 : m;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_EXPONENT) begin
      key_exponent = value;
    end else if (idx == REG_MODULUS) begin
      key_modulus = value;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [31:0] exponent, input logic [31:0] modulus);
    write_reg(REG_EXPONENT, exponent);
    write_reg(REG_MODULUS, modulus);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_powers.size() != 0);
  endtask

  task automatic send_base(input logic [31:0] base, input logic known,
                           input logic [31:0] power);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= base;
    do @(posedge clk); while (!s_axis_tready);
    pending_powers.push_back(known ? power : mod_power(base, key_exponent, key_modulus));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_powers.size() == 0) begin
        $error("power_result: expected none, got %h", m_axis_tdata);
        error_count++;
      end else begin
        oldest_power = pending_powers.pop_front();
        if (m_axis_tdata !== oldest_power) begin
          $error("power_result: expected %h, got %h", oldest_power, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  // Random backpressure, plus one long hold on request.
  initial begin : sink
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    power_case_t row;
    logic [31:0] next_exp;
    logic [31:0] next_mod;
    logic [31:0] base;
    int          count;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Unused indexes must leave the key untouched.
    write_reg(REG_UNUSED_2, 32'hA5A5_A5A5);
    write_reg(REG_UNUSED_3, 32'h0000_0000);

    for (int i = 0; i < NUM_VEC; i++) begin
      row = DIRECTED[i];
      if (row.exponent !== key_exponent || row.modulus !== key_modulus) begin
        drain();
        load_key(row.exponent, row.modulus);
      end
      send_base(row.base, row.known, row.power);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin next_exp = rand_exponent(1, 8);   next_mod = rand_modulus(); end
        1: begin next_exp = 32'd1;                 next_mod = rand_modulus(); end
        2: begin next_exp = rand_exponent(9, 16);  next_mod = $urandom_range(2, 255); end
        3: begin next_exp = rand_exponent(32, 32); next_mod = rand_modulus(); end
        4: begin next_exp = 32'd1 << $urandom_range(1, 15); next_mod = rand_modulus(); end
        5: begin next_exp = rand_exponent(1, 16);  next_mod = 32'd2; end
        6: begin next_exp = rand_exponent(1, 12);  next_mod = 32'hFFFF_FFFF; end
        7: begin next_exp = 32'hFFFF_FFFF;         next_mod = rand_modulus(); end
        8: begin next_exp = rand_exponent(1, 16);  next_mod = $urandom_range(2, 65535); end
        9: begin next_exp = 32'd65537;             next_mod = rand_modulus(); end
        default: begin next_exp = rand_exponent(1, 16); next_mod = rand_modulus(); end
      endcase
      count   = (p == 3 || p == 7) ? 40 : 75;
      idle_on = (p < NUM_PHASES - 2);
      drain();
      load_key(next_exp, next_mod);
      for (int n = 0; n < count; n++) begin
        if (p == 5 && n == 30) begin
          drain();
        end
        if (p == 10 && n == 0) begin
          hold_sink = 1'b1;
        end
        case ($urandom_range(0, 7))
          0:       base = $urandom_range(0, 3);
          1:       base = next_mod - 32'd1;
          2:       base = next_mod;
          3:       base = next_mod + 32'd1;
          4:       base = 32'hFFFF_FFFF;
          default: base = $urandom;
        endcase
        send_base(base, 1'b0, 32'd0);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
